// File: design/hrhbp_pkg.sv
package hrhbp_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_ACCUM    = 2'd1,
        CMD_FINALIZE = 2'd2,
        CMD_PROJECT  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ACC,
        ST_FIN,
        ST_PROJ,
        ST_OUT
    } t_state;

    localparam int NUM_CH   = 3;
    localparam int WEAK_DIV = 150;
    localparam int CAP_INT  = 100;
    localparam int PROJ_MAX = 255;

endpackage

// File: design/hrhbp_div.sv
module hrhbp_div import hrhbp_pkg::*; #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q, n_q;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic [DEN_W:0]   w_sh;

    always_comb begin
        w_sh  = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
        n_q   = {r_q[NUM_W-2:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {1'b0, r_den}) begin
            n_rem = w_sh - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_q;
endmodule

// File: design/hrhbp_lane.sv
module hrhbp_lane import hrhbp_pkg::*; #(
    parameter int BINS       = 256,
    parameter int COUNT_BITS = 20,
    parameter int FRAC_BITS  = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clr_we,
    input  logic [$clog2(BINS)-1:0]    i_clr_addr,
    input  logic                       i_acc_rd,
    input  logic                       i_acc_we,
    input  logic                       i_inner,
    input  logic [$clog2(BINS)-1:0]    i_addr,
    input  logic                       i_fin_rd,
    input  logic                       i_div_start,
    input  logic                       i_rt_we,
    input  logic [COUNT_BITS-1:0]      i_total,
    input  logic                       i_proj_rd,
    output logic                       o_div_busy,
    output logic [FRAC_BITS+7:0]       o_ratio
);
    localparam int AW    = $clog2(BINS);
    localparam int RW    = FRAC_BITS + 7;
    localparam int NUM_W = COUNT_BITS + FRAC_BITS;
    localparam int WW    = COUNT_BITS + 8;
    localparam logic [NUM_W-1:0] CAP = NUM_W'(CAP_INT) << FRAC_BITS;
    localparam logic [NUM_W-1:0] ONE = NUM_W'(1) << FRAC_BITS;

    logic [COUNT_BITS-1:0] r_inner_mem [BINS];
    logic [COUNT_BITS-1:0] r_outer_mem [BINS];
    logic [RW-1:0]         r_ratio_mem [BINS];
    logic                  r_tbl_valid;
    logic [COUNT_BITS-1:0] r_in_c, r_ou_c;
    logic [RW-1:0]         r_rd_ratio;
    logic                  r_rd_valid;
    logic [NUM_W-1:0]      w_quo;
    logic [NUM_W-1:0]      w_ratio;
    logic [COUNT_BITS-1:0] w_max;
    logic [WW-1:0]         w_ou_scaled;
    logic                  w_weak;

    assign w_max = '1;

    // outer <= total / WEAK_DIV  <=>  outer * WEAK_DIV <= total
    assign w_ou_scaled = WW'(r_ou_c) * WW'(WEAK_DIV);
    assign w_weak      = (w_ou_scaled <= WW'(i_total));

    always_ff @(posedge i_clk) begin
        if (i_acc_rd || i_fin_rd) begin
            r_in_c <= r_inner_mem[i_addr];
            r_ou_c <= r_outer_mem[i_addr];
        end
        if (i_clr_we) begin
            r_inner_mem[i_clr_addr] <= '0;
            r_outer_mem[i_clr_addr] <= '0;
        end else if (i_acc_we) begin
            r_outer_mem[i_addr] <= (r_ou_c == w_max) ? r_ou_c : r_ou_c + 1'b1;
            if (i_inner) begin
                r_inner_mem[i_addr] <= (r_in_c == w_max) ? r_in_c : r_in_c + 1'b1;
            end
        end
        if (i_rt_we) begin
            r_ratio_mem[i_addr] <= w_ratio[RW-1:0];
        end
        if (i_proj_rd) begin
            r_rd_ratio <= r_ratio_mem[i_addr];
        end
    end

    // finalize writes every entry in one pass, so one flag covers the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_valid <= 1'b0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_rt_we) begin
                r_tbl_valid <= 1'b1;
            end
            if (i_proj_rd) begin
                r_rd_valid <= r_tbl_valid;
            end
        end
    end

    hrhbp_div #(.NUM_W(NUM_W), .DEN_W(COUNT_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_div_start),
        .i_num   ({r_in_c, FRAC_BITS'(0)}),
        .i_den   (r_ou_c - r_in_c),
        .o_busy  (o_div_busy),
        .o_quo   (w_quo)
    );

    always_comb begin
        if (w_weak) begin
            w_ratio = '0;
        end else if (r_ou_c <= r_in_c) begin
            w_ratio = CAP;
        end else if (w_quo > CAP) begin
            w_ratio = CAP;
        end else if (w_quo < ONE) begin
            w_ratio = '0;
        end else begin
            w_ratio = w_quo;
        end
    end

    assign o_ratio = r_rd_valid ? r_rd_ratio : '0;
endmodule

// File: design/hrhbp_merge.sv
module hrhbp_merge import hrhbp_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_step,
    input  logic [FRAC_BITS+6:0] i_r0,
    input  logic [FRAC_BITS+6:0] i_r1,
    input  logic [FRAC_BITS+6:0] i_r2,
    output logic [7:0]           o_proj
);
    localparam int RW = FRAC_BITS + 7;
    localparam int PW = 2 * RW;
    localparam int TW = 3 * RW;

    logic [PW-1:0] r_p;
    logic [RW-1:0] r_r2;
    logic [TW-1:0] w_t;
    logic [TW-3*FRAC_BITS-1:0] w_int;

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_p  <= i_r0 * i_r1;
            r_r2 <= i_r2;
        end
    end

    assign w_t   = TW'(r_p) * TW'(r_r2);
    assign w_int = w_t[TW-1:3*FRAC_BITS];
    assign o_proj = (w_int > (TW-3*FRAC_BITS)'(PROJ_MAX)) ? 8'(PROJ_MAX) : w_int[7:0];
endmodule

// File: design/hsv_ratio_histogram_back_projection.sv
// channel | valid     | stall     | payload
// in      | i_valid   | o_stall   | i_cmd i_hue i_sat i_val i_in_inner
// out     | o_valid   | i_stall   | o_projected o_table_ready
// Clear: one bin address per cycle in all three lanes.
// Accumulate: read, increment, write back.
// Project: read, multiply, register; next item the cycle after the result leaves.
// Finalize: per bin: read, divider start, wait on the serial divider, ratio write.
// Reset runs a clear pass with o_stall high; ratios read 0 until a finalize.
// A result held under i_stall blocks the next item.
module hsv_ratio_histogram_back_projection import hrhbp_pkg::*; #(
    parameter int BINS       = 256,
    parameter int COUNT_BITS = 20,
    parameter int FRAC_BITS  = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_hue,
    input  logic [7:0] i_sat,
    input  logic [7:0] i_val,
    input  logic       i_in_inner,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_projected,
    output logic       o_table_ready
);
    localparam int AW = $clog2(BINS);
    localparam int RW = FRAC_BITS + 7;

    t_state r_state, n_state;
    logic [AW:0]   r_cnt;
    logic [2:0]    r_phase;
    logic [AW-1:0] r_idx [NUM_CH];
    logic          r_inner;
    logic [COUNT_BITS-1:0] r_total;
    logic [7:0]    r_proj;
    logic          r_ready_flag;
    logic [NUM_CH-1:0] w_busy;
    logic [RW-1:0] w_ratio [NUM_CH];
    logic [7:0]    w_proj;
    logic          w_acc;
    logic          w_clr_we, w_acc_rd, w_acc_we, w_fin_rd, w_div_start, w_rt_we;
    logic          w_proj_rd, w_merge_step;
    logic [AW-1:0] w_addr [NUM_CH];
    logic [AW-1:0] w_cnt_addr;

    assign w_acc = i_valid && !o_stall;
    assign w_cnt_addr = r_cnt[AW-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    case (t_cmd'(i_cmd))
                        CMD_CLEAR:    n_state = ST_CLEAR;
                        CMD_ACCUM:    n_state = ST_ACC;
                        CMD_FINALIZE: n_state = ST_FIN;
                        default:      n_state = ST_PROJ;
                    endcase
                end
            end
            ST_CLEAR: if (r_cnt == (AW+1)'(BINS - 1)) n_state = ST_IDLE;
            ST_ACC:   if (r_phase == 3'd1) n_state = ST_IDLE;
            ST_FIN: begin
                if (r_phase == 3'd3 && r_cnt == (AW+1)'(BINS - 1)) n_state = ST_OUT;
            end
            ST_PROJ:  if (r_phase == 3'd2) n_state = ST_OUT;
            ST_OUT:   if (!i_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_clr_we = 1'b0; w_acc_rd = 1'b0; w_acc_we = 1'b0; w_fin_rd = 1'b0;
        w_div_start = 1'b0; w_rt_we = 1'b0; w_proj_rd = 1'b0; w_merge_step = 1'b0;
        case (r_state)
            ST_CLEAR: w_clr_we = 1'b1;
            ST_ACC: begin
                w_acc_rd = (r_phase == 3'd0);
                w_acc_we = (r_phase == 3'd1);
            end
            ST_FIN: begin
                w_fin_rd    = (r_phase == 3'd0);
                w_div_start = (r_phase == 3'd1);
                w_rt_we     = (r_phase == 3'd3);
            end
            ST_PROJ: begin
                w_proj_rd    = (r_phase == 3'd0);
                w_merge_step = (r_phase == 3'd1);
            end
            default: ;
        endcase
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_addr[c] = (r_state == ST_FIN) ? w_cnt_addr : r_idx[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_phase <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    r_phase <= '0;
                    if (w_acc && t_cmd'(i_cmd) == CMD_CLEAR) r_total <= '0;
                    if (w_acc && t_cmd'(i_cmd) == CMD_ACCUM && i_in_inner
                        && r_total != '1) r_total <= r_total + 1'b1;
                end
                ST_CLEAR: r_cnt <= r_cnt + 1'b1;
                ST_ACC, ST_PROJ: r_phase <= r_phase + 1'b1;
                ST_FIN: begin
                    case (r_phase)
                        3'd2: if (!w_busy[0]) r_phase <= 3'd3;
                        3'd3: begin
                            r_phase <= '0;
                            r_cnt   <= r_cnt + 1'b1;
                        end
                        default: r_phase <= r_phase + 1'b1;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_acc) begin
            r_idx[0] <= i_hue[7 -: AW];
            r_idx[1] <= i_sat[7 -: AW];
            r_idx[2] <= i_val[7 -: AW];
            r_inner  <= i_in_inner;
            r_ready_flag <= (t_cmd'(i_cmd) == CMD_FINALIZE);
        end
        if (r_state == ST_PROJ && r_phase == 3'd2) r_proj <= w_proj;
        if (r_state == ST_FIN) r_proj <= '0;
    end

    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        hrhbp_lane #(.BINS(BINS), .COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_clr_we    (w_clr_we),
            .i_clr_addr  (w_cnt_addr),
            .i_acc_rd    (w_acc_rd),
            .i_acc_we    (w_acc_we),
            .i_inner     (r_inner),
            .i_addr      (w_addr[c]),
            .i_fin_rd    (w_fin_rd),
            .i_div_start (w_div_start),
            .i_rt_we     (w_rt_we),
            .i_total     (r_total),
            .i_proj_rd   (w_proj_rd),
            .o_div_busy  (w_busy[c]),
            .o_ratio     (w_ratio[c])
        );
    end

    hrhbp_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .i_clk  (i_clk),
        .i_step (w_merge_step),
        .i_r0   (w_ratio[0]),
        .i_r1   (w_ratio[1]),
        .i_r2   (w_ratio[2]),
        .o_proj (w_proj)
    );

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = (r_state == ST_OUT);
    assign o_projected   = r_proj;
    assign o_table_ready = r_ready_flag;

    a_out_only_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == ST_FIN || $past(r_state) == ST_PROJ))
        else $error("result without work");
    a_finalize_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_ready) |-> (o_projected == 8'd0))
        else $error("finalize result nonzero");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped");
endmodule

// File: dv/tb_hsv_ratio_histogram_back_projection.sv
module tb_hsv_ratio_histogram_back_projection;
    import hrhbp_pkg::*;

    localparam int BINS      = 256;
    localparam int FRAC_BITS = 8;
    localparam int ALL_BINS  = NUM_CH * BINS;
    localparam longint unsigned RATIO_ONE = 64'd1 << FRAC_BITS;
    localparam longint unsigned RATIO_CAP = CAP_INT * RATIO_ONE;

    typedef struct {
        logic [7:0] projected;
        logic       table_ready;
    } t_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_cmd;
    logic [7:0] i_hue;
    logic [7:0] i_sat;
    logic [7:0] i_val;
    logic       i_in_inner;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_projected;
    logic       o_table_ready;

    int unsigned     inner_cnt [ALL_BINS];
    int unsigned     outer_cnt [ALL_BINS];
    longint unsigned ratio_lut [ALL_BINS];
    int unsigned     inner_total;
    t_result         pending_results[$];
    int              errors;
    bit              calm;

    hsv_ratio_histogram_back_projection uut (.*);

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < 22);
    end

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item projected=%0d ready=%0b", $time,
                         o_projected, o_table_ready);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (want.projected !== o_projected) begin
                    $display("%0t: projected expected %0d actual %0d", $time,
                             want.projected, o_projected);
                    errors++;
                end
                if (want.table_ready !== o_table_ready) begin
                    $display("%0t: table_ready expected %0b actual %0b", $time,
                             want.table_ready, o_table_ready);
                    errors++;
                end
            end
        end
    end

    function automatic int unsigned bump(int unsigned c);
        return (c >= 32'hFFFFF) ? 32'hFFFFF : c + 1;
    endfunction

    task automatic update_histograms(t_cmd cmd, logic [7:0] h, logic [7:0] s,
                                     logic [7:0] v, logic inner);
        int unsigned     idx [3];
        int unsigned     thd;
        longint unsigned in_c, ou_c, r, prod;
        t_result         res;
        idx[0] = h;
        idx[1] = BINS + s;
        idx[2] = 2 * BINS + v;
        case (cmd)
            CMD_CLEAR: begin
                foreach (inner_cnt[i]) begin
                    inner_cnt[i] = 0;
                    outer_cnt[i] = 0;
                end
                inner_total = 0;
            end
            CMD_ACCUM: begin
                for (int c = 0; c < 3; c++) begin
                    outer_cnt[idx[c]] = bump(outer_cnt[idx[c]]);
                    if (inner)
                        inner_cnt[idx[c]] = bump(inner_cnt[idx[c]]);
                end
                if (inner)
                    inner_total = bump(inner_total);
            end
            CMD_FINALIZE: begin
                thd = inner_total / WEAK_DIV;
                for (int i = 0; i < ALL_BINS; i++) begin
                    in_c = inner_cnt[i];
                    ou_c = outer_cnt[i];
                    if (ou_c <= thd) begin
                        r = 0;
                    end else begin
                        if (ou_c <= in_c)
                            r = RATIO_CAP;
                        else begin
                            r = (in_c << FRAC_BITS) / (ou_c - in_c);
                            if (r > RATIO_CAP)
                                r = RATIO_CAP;
                        end
                        if (r < RATIO_ONE)
                            r = 0;
                    end
                    ratio_lut[i] = r;
                end
                res.projected = 0;
                res.table_ready = 1;
                pending_results.push_back(res);
            end
            default: begin
                prod = (ratio_lut[idx[0]] * ratio_lut[idx[1]] * ratio_lut[idx[2]])
                       >> (3 * FRAC_BITS);
                res.projected = (prod > PROJ_MAX) ? 8'(PROJ_MAX) : 8'(prod);
                res.table_ready = 0;
                pending_results.push_back(res);
            end
        endcase
    endtask

    task automatic send_item(t_cmd cmd, logic [7:0] h, logic [7:0] s,
                             logic [7:0] v, logic inner);
        while (!calm && $urandom_range(99) < 22) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_hue      <= h;
        i_sat      <= s;
        i_val      <= v;
        i_in_inner <= inner;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        update_histograms(cmd, h, s, v, inner);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_reset_projection;
        send_item(CMD_PROJECT, 8'd0, 8'd0, 8'd0, 1'b0);
        send_item(CMD_PROJECT, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    endtask

    task automatic test_directed_table;
        send_item(CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_item(CMD_ACCUM, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_item(CMD_ACCUM, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_item(CMD_ACCUM, 8'd0, 8'd0, 8'd0, 1'b1);
        repeat (3) send_item(CMD_ACCUM, 8'd0, 8'd0, 8'd0, 1'b0);
        repeat (2) send_item(CMD_ACCUM, 8'd128, 8'd128, 8'd128, 1'b1);
        send_item(CMD_ACCUM, 8'd128, 8'd128, 8'd128, 1'b0);
        send_item(CMD_FINALIZE, 8'hAA, 8'h55, 8'hFF, 1'b1);
        send_item(CMD_PROJECT, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_item(CMD_PROJECT, 8'd0, 8'd0, 8'd0, 1'b1);
        send_item(CMD_PROJECT, 8'd128, 8'd128, 8'd128, 1'b0);
        send_item(CMD_PROJECT, 8'd128, 8'd128, 8'hFF, 1'b0);
        send_item(CMD_PROJECT, 8'hFF, 8'd128, 8'd0, 1'b0);
        send_item(CMD_PROJECT, 8'd7, 8'd128, 8'hFF, 1'b1);
    endtask

    // weak bin threshold needs >= 150 inner pixels; accumulates with no idling
    task automatic test_weak_bins;
        calm = 1;
        send_item(CMD_CLEAR, 8'd0, 8'd0, 8'd0, 1'b0);
        repeat (300) send_item(CMD_ACCUM, 8'd10, 8'd20, 8'd30, 1'b1);
        repeat (2) send_item(CMD_ACCUM, 8'd50, 8'd60, 8'd70, 1'b1);
        repeat (3) send_item(CMD_ACCUM, 8'd90, 8'd100, 8'd110, 1'b1);
        calm = 0;
        drain();
        send_item(CMD_FINALIZE, 8'd0, 8'd0, 8'd0, 1'b0);
        send_item(CMD_PROJECT, 8'd10, 8'd20, 8'd30, 1'b0);
        send_item(CMD_PROJECT, 8'd50, 8'd60, 8'd70, 1'b0);
        send_item(CMD_PROJECT, 8'd90, 8'd100, 8'd110, 1'b0);
        send_item(CMD_PROJECT, 8'd10, 8'd100, 8'd70, 1'b0);
    endtask

    function automatic logic [7:0] pick(logic [7:0] pal [8]);
        return ($urandom_range(7) == 0) ? 8'($urandom) : pal[$urandom_range(7)];
    endfunction

    task automatic test_random_frames;
        logic [7:0] pal [3][8];
        for (int rnd = 0; rnd < 6; rnd++) begin
            foreach (pal[c, k])
                pal[c][k] = 8'($urandom);
            send_item(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
            for (int n = 0; n < 120; n++)
                send_item(CMD_ACCUM, pick(pal[0]), pick(pal[1]), pick(pal[2]),
                          $urandom_range(99) < 40);
            send_item(CMD_FINALIZE, 8'($urandom), 8'($urandom), 8'($urandom),
                      1'($urandom));
            for (int n = 0; n < 80; n++)
                send_item(CMD_PROJECT, pick(pal[0]), pick(pal[1]), pick(pal[2]),
                          1'($urandom));
            if (rnd == 3)
                drain();
        end
    endtask

    initial begin
        int guard;
        errors     = 0;
        calm       = 0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_cmd      = CMD_CLEAR;
        i_hue      = '0;
        i_sat      = '0;
        i_val      = '0;
        i_in_inner = 1'b0;
        i_stall    = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_projection();
        test_directed_table();
        test_weak_bins();
        test_random_frames();

        @(posedge i_clk);
        i_valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (300) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
